FILE: design/cobs_motion_frame_receiver_defines.svh
// Assertion macros shared by the receiver RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef COBS_MOTION_FRAME_RECEIVER_DEFINES_SVH
`define COBS_MOTION_FRAME_RECEIVER_DEFINES_SVH

// check sampled on clk, suspended while reset is asserted
`define CMFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check sampled on clk, also active during reset
`define CMFR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/cmfr_pkg.sv
// Package for the COBS motion frame receiver: constants, phase codes, token type.
// No dependencies.
`default_nettype none

package cmfr_pkg;

	localparam logic [7:0] FRAME_MARKER_RESET = 8'h3E;
	localparam logic [7:0] CODE_END           = 8'h00;
	localparam logic [7:0] CODE_MAX           = 8'hFF;
	localparam logic [2:0] HEADER_LEN         = 3'd3;
	localparam logic [2:0] INTERVAL_LEN       = 3'd6;

	localparam int TIME_BYTES = 4;
	localparam int TIME_KEEP  = (TIME_BYTES < 4) ? TIME_BYTES : 4;

	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [1:0] PHASE_HEADER   = 2'd0;
	localparam logic [1:0] PHASE_INTERVAL = 2'd1;
	localparam logic [1:0] PHASE_DX       = 2'd2;
	localparam logic [1:0] PHASE_DY       = 2'd3;

	typedef struct packed {
		logic [1:0] phase;
		logic [2:0] idx;
		logic [7:0] val;
		logic       have;
		logic       last;
	} token_t;

	typedef struct packed {
		logic take;
		logic emit;
	} back_status_t;

endpackage

`default_nettype wire

FILE: design/cmfr_front.sv
// Front end: per-byte COBS decoding, chunk tracking and header matching.
// Emits decoded-byte tokens for frame chunks. Depends on cmfr_pkg.
`default_nettype none

module cmfr_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      rx_byte,
	input  wire logic [7:0]      frame_marker,
	output logic                 tok_valid,
	output cmfr_pkg::token_t     tok
);
	import cmfr_pkg::*;

	logic [1:0] phase_q;
	logic [2:0] pos_q;
	logic [7:0] run_q;
	logic       ovh_q;
	logic       ended_q;
	logic [2:0] dcnt_q;
	logic       hmatch_q;

	logic       have;
	logic [7:0] val;
	logic [7:0] run_nx;
	logic       ovh_nx;
	logic       ended_nx;
	logic [2:0] dcnt_nx;
	logic       hmatch_nx;
	logic [2:0] pos_nx;
	logic [2:0] len;
	logic       last;
	logic [1:0] phase_nx;

	always_comb begin
		have      = 1'b0;
		val       = CODE_END;
		run_nx    = run_q;
		ovh_nx    = ovh_q;
		ended_nx  = ended_q;
		if (!ended_q) begin
			if (run_q != 8'd0) begin
				have   = 1'b1;
				val    = rx_byte;
				run_nx = run_q - 8'd1;
			end else if (rx_byte == CODE_END) begin
				ended_nx = 1'b1;
			end else begin
				have   = !ovh_q;
				run_nx = rx_byte - 8'd1;
				ovh_nx = (rx_byte == CODE_MAX);
			end
		end
		dcnt_nx   = have ? dcnt_q + 3'd1 : dcnt_q;
		hmatch_nx = hmatch_q;
		if (have && phase_q == PHASE_HEADER && dcnt_q == 3'd0)
			hmatch_nx = (val == frame_marker);
		len    = (phase_q == PHASE_INTERVAL) ? INTERVAL_LEN : HEADER_LEN;
		pos_nx = pos_q + 3'd1;
		last   = (pos_nx >= len);
		unique case (phase_q)
			PHASE_HEADER:   phase_nx = (dcnt_nx == 3'd1 && hmatch_nx) ? PHASE_INTERVAL
			                                                          : PHASE_HEADER;
			PHASE_INTERVAL: phase_nx = PHASE_DX;
			PHASE_DX:       phase_nx = PHASE_DY;
			PHASE_DY:       phase_nx = PHASE_HEADER;
			default:        phase_nx = PHASE_HEADER;
		endcase
	end

	assign tok_valid = accept && (phase_q != PHASE_HEADER) &&
	                   (have || (last && phase_q == PHASE_DY));
	assign tok.phase = phase_q;
	assign tok.idx   = dcnt_q;
	assign tok.val   = val;
	assign tok.have  = have;
	assign tok.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_HEADER;
			pos_q    <= 3'd0;
			run_q    <= 8'd0;
			ovh_q    <= 1'b1;
			ended_q  <= 1'b0;
			dcnt_q   <= 3'd0;
			hmatch_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				phase_q  <= phase_nx;
				pos_q    <= 3'd0;
				run_q    <= 8'd0;
				ovh_q    <= 1'b1;
				ended_q  <= 1'b0;
				dcnt_q   <= 3'd0;
				hmatch_q <= 1'b0;
			end else begin
				pos_q    <= pos_nx;
				run_q    <= run_nx;
				ovh_q    <= ovh_nx;
				ended_q  <= ended_nx;
				dcnt_q   <= dcnt_nx;
				hmatch_q <= hmatch_nx;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/cmfr_queue.sv
// Token queue between front and back end, register storage with head/tail pointers.
// Depends on cmfr_pkg.
`default_nettype none

module cmfr_queue #(
	parameter int DEPTH = cmfr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire cmfr_pkg::token_t wr_data,
	input  wire logic             rd_en,
	output cmfr_pkg::token_t      rd_data,
	output logic                  q_empty,
	output logic                  q_full
);
	import cmfr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	token_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign q_empty = (cnt_q == '0);
	assign q_full  = (cnt_q == FULL_CNT);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + CW'(1);
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

FILE: design/cmfr_back.sv
// Back end: assembles interval, dx and dy from tokens and holds the result register.
// Depends on cmfr_pkg.
`default_nettype none

module cmfr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire cmfr_pkg::token_t tok,
	output logic                  q_pop,
	input  wire logic             pop,
	output logic                  empty,
	output logic [31:0]           time_interval,
	output logic signed [7:0]     delta_x,
	output logic signed [7:0]     delta_y,
	output cmfr_pkg::back_status_t status
);
	import cmfr_pkg::*;

	logic [31:0] time_q;
	logic [7:0]  dx_q;
	logic [7:0]  dy_q;
	logic        out_valid_q;
	logic [31:0] res_time_q;
	logic [7:0]  res_dx_q;
	logic [7:0]  res_dy_q;

	logic [31:0] time_nx;
	logic [7:0]  dx_nx;
	logic [7:0]  dy_nx;
	logic        ends_frame;
	logic        slot_free;
	logic        take;
	logic        emit;

	always_comb begin
		time_nx = time_q;
		dx_nx   = dx_q;
		dy_nx   = dy_q;
		if (tok.have) begin
			unique case (tok.phase)
				PHASE_INTERVAL: begin
					for (int i = 0; i < 4; i++) begin
						if (i < TIME_KEEP && tok.idx == 3'(i))
							time_nx[8*i +: 8] = time_q[8*i +: 8] | tok.val;
					end
				end
				PHASE_DX: if (tok.idx == 3'd0) dx_nx = tok.val;
				PHASE_DY: if (tok.idx == 3'd0) dy_nx = tok.val;
				default: ;
			endcase
		end
	end

	assign ends_frame  = tok.last && (tok.phase == PHASE_DY);
	assign slot_free   = !out_valid_q || pop;
	assign take        = !q_empty && (!ends_frame || slot_free);
	assign emit        = take && ends_frame;
	assign q_pop       = take;
	assign status.take = take;
	assign status.emit = emit;

	assign empty         = !out_valid_q;
	assign time_interval = res_time_q;
	assign delta_x       = res_dx_q;
	assign delta_y       = res_dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				time_q <= '0;
				dx_q   <= '0;
				dy_q   <= '0;
			end else if (take) begin
				time_q <= time_nx;
				dx_q   <= dx_nx;
				dy_q   <= dy_nx;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_time_q <= time_nx;
			res_dx_q   <= dx_nx;
			res_dy_q   <= dy_nx;
		end
	end

endmodule

`default_nettype wire

FILE: design/cobs_motion_frame_receiver.sv
// COBS motion frame receiver.
// Input queue side: drive rx_byte with push; a byte transfers on a clock edge where
// push is high and full is low. One byte per cycle is sustained while full stays low.
// Bytes are taken in chunks of 3 (header), 6 (interval), 3 (dx), 3 (dy), each COBS
// decoded on its own. A header that decodes to exactly frame_marker opens a frame;
// otherwise its 3 bytes are dropped and the next chunk is tried as a header.
// Result queue side: while empty is low, time_interval/delta_x/delta_y hold the
// oldest frame; it transfers on an edge where pop is high. A result appears after
// the last dy byte transfers: its token is first registered in the token queue,
// then the back end loads the result register once that register is free. A frame
// takes at least 15 byte transfers.
// If pop stays low, the result register holds, the next frame's last token waits
// and tokens behind it collect in the token queue (QUEUE_DEPTH entries); when it
// fills, full rises and input stops.
// Configuration: cfg_data transfers on cfg_valid && cfg_ready (always ready) and sets
// the header marker byte; write it only while the block is idle.
// Reset: marker returns to 0x3E, decoding restarts on a header chunk, no result.
// Depends on cmfr_pkg, cmfr_front, cmfr_queue, cmfr_back and the defines header.
`default_nettype none

`include "cobs_motion_frame_receiver_defines.svh"

module cobs_motion_frame_receiver #(
	parameter int QUEUE_DEPTH = cmfr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      time_interval,
	output logic signed [7:0] delta_x,
	output logic signed [7:0] delta_y,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);
	import cmfr_pkg::*;

	logic         [7:0] marker_q;
	logic               accept;
	logic               tok_valid;
	token_t             tok_in;
	token_t             tok_out;
	logic               q_empty;
	logic               q_full;
	logic               q_pop;
	back_status_t       status;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			marker_q <= FRAME_MARKER_RESET;
		else if (cfg_valid && cfg_ready)
			marker_q <= cfg_data;
	end

	cmfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.frame_marker (marker_q),
		.tok_valid    (tok_valid),
		.tok          (tok_in)
	);

	cmfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tok_valid),
		.wr_data (tok_in),
		.rd_en   (q_pop),
		.rd_data (tok_out),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	cmfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.tok           (tok_out),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.time_interval (time_interval),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.status        (status)
	);

	`CMFR_ASSERT(a_no_write_when_full, !(tok_valid && q_full), "token written to full queue")
	`CMFR_ASSERT(a_take_needs_token, status.take |-> !q_empty, "token taken from empty queue")
	`CMFR_ASSERT(a_emit_shows_result, status.emit |=> !empty, "emitted frame not presented")
	`CMFR_ASSERT_ALWAYS(a_emit_needs_slot, status.emit |-> (empty || pop), "result overwritten")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for cobs_motion_frame_receiver: directed and random byte streams,
// frame prediction in the bench, random idling on both queue sides and a long result stall.
// Depends on cmfr_pkg and the receiver RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cmfr_pkg::*;

	localparam logic [7:0] CODE_NO_DATA  = 8'h01;
	localparam logic [7:0] CODE_ONE_DATA = 8'h02;
	localparam logic [7:0] CODE_TWO_DATA = 8'h03;

	typedef struct {
		logic [31:0]       interval;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
	} motion_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              push      = 1'b0;
	logic [7:0]        rx_byte   = 8'h00;
	logic              pop       = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [7:0]        cfg_data  = 8'h00;
	logic              full;
	logic              empty;
	logic              cfg_ready;
	logic [31:0]       time_interval;
	logic signed [7:0] delta_x;
	logic signed [7:0] delta_y;

	cobs_motion_frame_receiver uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.time_interval (time_interval),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// frame decoder state, mirrors the block
	logic [7:0]  marker     = FRAME_MARKER_RESET;
	logic [1:0]  rx_phase   = PHASE_HEADER;
	logic [2:0]  rx_pos     = 3'd0;
	logic [7:0]  run_left   = 8'd0;
	bit          after_ff   = 1'b1;
	bit          chunk_done = 1'b0;
	logic [2:0]  byte_count = 3'd0;
	bit          marker_hit = 1'b0;
	logic [31:0] acc_time   = 32'd0;
	logic [7:0]  acc_dx     = 8'd0;
	logic [7:0]  acc_dy     = 8'd0;

	motion_t expected_frames[$];
	int      errors          = 0;
	int      bytes_sent      = 0;
	int      hold_request    = 0;
	bit      sender_idles    = 1'b1;
	bit      receiver_idles  = 1'b1;

	function automatic void clear_chunk();
		rx_pos     = 3'd0;
		run_left   = 8'd0;
		after_ff   = 1'b1;
		chunk_done = 1'b0;
		byte_count = 3'd0;
		marker_hit = 1'b0;
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		logic       have;
		logic [7:0] val;
		logic [2:0] chunk_len;
		motion_t    m;
		have = 1'b0;
		val = 8'd0;
		chunk_len = (rx_phase == PHASE_INTERVAL) ? INTERVAL_LEN : HEADER_LEN;
		if (!chunk_done) begin
			if (run_left != 8'd0) begin
				have = 1'b1;
				val = b;
				run_left = run_left - 8'd1;
			end else if (b == CODE_END) begin
				chunk_done = 1'b1;
			end else begin
				if (!after_ff) begin
					have = 1'b1;
					val = 8'd0;
				end
				run_left = b - 8'd1;
				after_ff = (b == CODE_MAX);
			end
		end
		if (have) begin
			case (rx_phase)
				PHASE_HEADER: begin
					if (byte_count == 3'd0)
						marker_hit = (val == marker);
				end
				PHASE_INTERVAL: begin
					if (byte_count < TIME_BYTES && byte_count < 4)
						acc_time = acc_time | ({24'd0, val} << (8 * byte_count));
				end
				PHASE_DX: begin
					if (byte_count == 3'd0)
						acc_dx = val;
				end
				default: begin
					if (byte_count == 3'd0)
						acc_dy = val;
				end
			endcase
			byte_count = byte_count + 3'd1;
		end
		rx_pos = rx_pos + 3'd1;
		if (rx_pos >= chunk_len) begin
			case (rx_phase)
				PHASE_HEADER:   rx_phase = (byte_count == 3'd1 && marker_hit) ?
						PHASE_INTERVAL : PHASE_HEADER;
				PHASE_INTERVAL: rx_phase = PHASE_DX;
				PHASE_DX:       rx_phase = PHASE_DY;
				default: begin
					m.interval = acc_time;
					m.dx = acc_dx;
					m.dy = acc_dy;
					expected_frames.push_back(m);
					acc_time = 32'd0;
					acc_dx = 8'd0;
					acc_dy = 8'd0;
					rx_phase = PHASE_HEADER;
				end
			endcase
			clear_chunk();
		end
	endfunction

	// biased toward end codes, 0xFF codes and short runs
	function automatic logic [7:0] noisy_byte();
		int r;
		r = $urandom_range(0, 15);
		if (r < 4)
			return CODE_END;
		else if (r < 6)
			return CODE_MAX;
		else if (r < 10)
			return 8'($urandom_range(1, 7));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = sender_idles ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic send_chunk(input int len);
		if ($urandom_range(0, 1)) begin
			send_byte(8'(len));
			repeat (len - 1) send_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat (len) send_byte(noisy_byte());
		end
	endtask

	task automatic send_header();
		int r;
		r = $urandom_range(0, 7);
		if (r < 5) begin
			send_byte(CODE_ONE_DATA);
			send_byte(marker);
			send_byte(CODE_END);
		end else if (r == 5) begin
			send_byte(CODE_ONE_DATA);
			send_byte(marker);
			send_byte(8'($urandom_range(0, 255)));
		end else if (r == 6) begin
			send_byte(CODE_NO_DATA);
			send_byte(CODE_NO_DATA);
			send_byte(CODE_END);
		end else begin
			send_byte(CODE_MAX);
			send_byte(marker);
			send_byte(noisy_byte());
		end
	endtask

	task automatic send_frame();
		send_header();
		send_chunk(INTERVAL_LEN);
		send_chunk(HEADER_LEN);
		send_chunk(HEADER_LEN);
	endtask

	// pad to a header boundary, then let every result drain and the pipeline go quiet
	task automatic settle();
		while (rx_phase != PHASE_HEADER || rx_pos != 3'd0)
			send_byte(CODE_END);
		push <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_marker(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		marker = value;
	endtask

	task automatic check_header_mismatch();
		send_byte(CODE_ONE_DATA);
		send_byte(marker ^ 8'h01);
		send_byte(CODE_END);
		// two decoded bytes, first one matches
		send_byte(CODE_TWO_DATA);
		send_byte(marker);
		send_byte(marker);
		settle();
	endtask

	task automatic check_empty_chunks();
		send_byte(CODE_ONE_DATA);
		send_byte(marker);
		send_byte(CODE_END);
		send_byte(CODE_END);
		repeat (5) send_byte(CODE_MAX);
		send_byte(CODE_END);
		send_byte(CODE_ONE_DATA);
		send_byte(8'h55);
		send_byte(CODE_ONE_DATA);
		send_byte(8'h80);
		send_byte(CODE_END);
		settle();
	endtask

	task automatic check_surplus_interval();
		send_byte(CODE_ONE_DATA);
		send_byte(marker);
		send_byte(CODE_END);
		send_byte(CODE_MAX);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(CODE_ONE_DATA);
		send_byte(8'h7F);
		send_byte(CODE_END);
		// zero inserted between two short codes
		send_byte(CODE_NO_DATA);
		send_byte(CODE_NO_DATA);
		send_byte(CODE_END);
		settle();
	endtask

	task automatic check_backpressure();
		hold_request = 400;
		sender_idles = 1'b0;
		repeat (5) send_frame();
		sender_idles = 1'b1;
		settle();
	endtask

	task automatic check_random_frames(input int count);
		int start;
		int r;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			if ($urandom_range(0, 15) == 0)
				sender_idles = !sender_idles;
			if ($urandom_range(0, 15) == 0)
				receiver_idles = !receiver_idles;
			r = $urandom_range(0, 9);
			if (r < 8) begin
				send_frame();
			end else if (r == 8) begin
				repeat (3) send_byte(noisy_byte());
			end else begin
				send_header();
				repeat ($urandom_range(1, 11)) send_byte(noisy_byte());
			end
		end
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		settle();
	endtask

	task automatic check_marker_settings();
		logic [7:0] settings[4];
		settings = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), FRAME_MARKER_RESET};
		foreach (settings[i]) begin
			write_marker(settings[i]);
			check_random_frames(450);
		end
	endtask

	initial begin : result_checker
		int      stall;
		motion_t want;
		@(posedge arst_n);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 18) : 0;
			if (hold_request != 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (expected_frames.size() == 0) begin
				$error("unexpected frame: time_interval %0h delta_x %0d delta_y %0d",
					time_interval, delta_x, delta_y);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				if (time_interval !== want.interval) begin
					$error("time_interval expected %0h got %0h", want.interval, time_interval);
					errors++;
				end
				if (delta_x !== want.dx) begin
					$error("delta_x expected %0d got %0d", want.dx, delta_x);
					errors++;
				end
				if (delta_y !== want.dy) begin
					$error("delta_y expected %0d got %0d", want.dy, delta_y);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_header_mismatch();
		check_empty_chunks();
		check_surplus_interval();
		check_backpressure();
		check_marker_settings();
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
